### src/calts_pkg.sv
package calts_pkg;

  // Widths of the calendar fields and of the results.
  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOURS_W = 5;
  localparam int MIN_W   = 6;
  localparam int SECS_W  = 6;
  localparam int SUB_W   = 10;
  localparam int SEC_W   = 32;
  localparam int TS_W    = 42;
  localparam int MS_W    = 10;
  localparam int HMS_W   = 17;

  // Default and largest number of sub-second bits.
  localparam int SUBSEC_BITS_DEF = 10;
  localparam int SUBSEC_BITS_MAX = 15;

  // Packed two-bit day corrections, one field per month.
  localparam logic [31:0] CORR_LEAP = 32'h0044_5550;
  localparam logic [31:0] CORR_NORM = 32'h0099_AAA0;

  localparam logic [10:0] DAYS_PER_4YR = 11'd1461;
  localparam logic [5:0]  DAYS_PER_2MO = 6'd61;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

  // Beat leaving the day-count stage.
  typedef struct packed {
    logic [SEC_W-1:0] days;
    logic [HMS_W-1:0] hms;
  } days_beat_t;

  // Beat leaving the scaling stage.
  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic [SEC_W-1:0] seconds_ms;
    logic [MS_W-1:0]  ms;
    logic [TS_W-1:0]  ts;
  } scale_beat_t;

endpackage

### src/calendar_to_tick_timestamp_core.sv
// Converts one calendar reading (years since 2000, month, day, hours, minutes,
// seconds and the sub-second down-counter) into whole seconds since
// 2000-01-01 00:00:00, a tick timestamp with SUBSEC_BITS fraction bits, the
// milliseconds within the second and the total milliseconds modulo 2^32.
// The datapath is a four-stage pipeline of constant multipliers: day count,
// seconds, scaling, then the final millisecond sum. One reading is taken
// every cycle while results are drained; each stage holds its beat under
// back-pressure, so nothing is lost or repeated. Out-of-range fields wrap
// as plain binary arithmetic modulo 2^32.
module calendar_to_tick_timestamp_core #(
  parameter int SUBSEC_BITS = calts_pkg::SUBSEC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [calts_pkg::YEAR_W-1:0]  year,
  input  logic [calts_pkg::MONTH_W-1:0] month,
  input  logic [calts_pkg::DAY_W-1:0]   day,
  input  logic [calts_pkg::HOURS_W-1:0] hours,
  input  logic [calts_pkg::MIN_W-1:0]   minutes,
  input  logic [calts_pkg::SECS_W-1:0]  secs,
  input  logic [calts_pkg::SUB_W-1:0]   subsecond_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [calts_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [calts_pkg::TS_W-1:0]    tick_timestamp,
  output logic [calts_pkg::MS_W-1:0]    subsecond_ms,
  output logic [calts_pkg::SEC_W-1:0]   total_ms
);
  import calts_pkg::*;

  logic                   d_valid;
  logic                   d_ready;
  days_beat_t             d_beat;
  logic [SUBSEC_BITS-1:0] d_ticks;

  logic                   s_valid;
  logic                   s_ready;
  logic [SEC_W-1:0]       s_seconds;
  logic [SUBSEC_BITS-1:0] s_ticks;
  logic [SUBSEC_BITS+9:0] s_ms_prod;

  logic                   c_valid;
  logic                   c_ready;
  scale_beat_t            c_beat;

  // Stage one: day count, seconds within the day and elapsed ticks.
  calts_days #(
    .SUBSEC_BITS(SUBSEC_BITS)
  ) u_days (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .year            (year),
    .month           (month),
    .day             (day),
    .hours           (hours),
    .minutes         (minutes),
    .secs            (secs),
    .subsecond_count (subsecond_count),
    .out_valid       (d_valid),
    .out_ready       (d_ready),
    .out_beat        (d_beat),
    .out_ticks       (d_ticks)
  );

  // Stage two: whole seconds and the scaled ticks.
  calts_secs #(
    .SUBSEC_BITS(SUBSEC_BITS)
  ) u_secs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_beat   (d_beat),
    .in_ticks  (d_ticks),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .seconds   (s_seconds),
    .ticks     (s_ticks),
    .ms_prod   (s_ms_prod)
  );

  // Stage three: timestamp, milliseconds and seconds in milliseconds.
  calts_scale #(
    .SUBSEC_BITS(SUBSEC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .seconds   (s_seconds),
    .ticks     (s_ticks),
    .ms_prod   (s_ms_prod),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_beat  (c_beat)
  );

  // Stage four: total milliseconds and the output register.
  calts_out u_out (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (c_valid),
    .in_ready        (c_ready),
    .in_beat         (c_beat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .elapsed_seconds (elapsed_seconds),
    .tick_timestamp  (tick_timestamp),
    .subsecond_ms    (subsecond_ms),
    .total_ms        (total_ms)
  );

endmodule

### src/calts_days.sv
module calts_days #(
  parameter int SUBSEC_BITS = calts_pkg::SUBSEC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [calts_pkg::YEAR_W-1:0]   year,
  input  logic [calts_pkg::MONTH_W-1:0]  month,
  input  logic [calts_pkg::DAY_W-1:0]    day,
  input  logic [calts_pkg::HOURS_W-1:0]  hours,
  input  logic [calts_pkg::MIN_W-1:0]    minutes,
  input  logic [calts_pkg::SECS_W-1:0]   secs,
  input  logic [calts_pkg::SUB_W-1:0]    subsecond_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output calts_pkg::days_beat_t          out_beat,
  output logic [SUBSEC_BITS-1:0]         out_ticks
);
  import calts_pkg::*;

  localparam int EXT_W = (SUBSEC_BITS > SUB_W) ? SUBSEC_BITS : SUB_W;

  logic [MONTH_W-1:0] mi;
  logic [31:0]        corr_word;
  logic [1:0]         corr;
  logic [17:0]        year_term;
  logic [9:0]         month_term;
  logic [11:0]        min_secs;
  logic [HMS_W-1:0]   hour_secs;
  logic [EXT_W-1:0]   sub_ext;
  days_beat_t         beat_next;
  logic [SUBSEC_BITS-1:0] ticks_next;

  // Day count since the epoch, with the month offset and its leap correction.
  always_comb begin
    mi         = month - MONTH_W'(1);
    corr_word  = (year[1:0] == 2'b00) ? CORR_LEAP : CORR_NORM;
    corr       = 2'(corr_word >> {mi, 1'b0});
    year_term  = 18'((18'(year) * 18'(DAYS_PER_4YR) + 18'd3) >> 2);
    month_term = 10'((10'(mi) * 10'(DAYS_PER_2MO) + 10'd1) >> 1);
    beat_next.days = SEC_W'(year_term) + SEC_W'(month_term) - SEC_W'(corr)
                     + SEC_W'(day) - SEC_W'(1);
  end

  // Seconds within the day, and ticks gone since the start of the second.
  always_comb begin
    min_secs  = 12'(minutes) * 12'(SEC_PER_MIN);
    hour_secs = HMS_W'(hours) * HMS_W'(SEC_PER_HOUR);
    beat_next.hms = HMS_W'(secs) + HMS_W'(min_secs) + hour_secs;
    sub_ext    = EXT_W'(subsecond_count);
    ticks_next = ~sub_ext[SUBSEC_BITS-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat  <= beat_next;
      out_ticks <= ticks_next;
    end
  end

endmodule

### src/calts_secs.sv
module calts_secs #(
  parameter int SUBSEC_BITS = calts_pkg::SUBSEC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  calts_pkg::days_beat_t             in_beat,
  input  logic [SUBSEC_BITS-1:0]            in_ticks,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [calts_pkg::SEC_W-1:0]       seconds,
  output logic [SUBSEC_BITS-1:0]            ticks,
  output logic [SUBSEC_BITS+9:0]            ms_prod
);
  import calts_pkg::*;

  logic [SEC_W-1:0]         seconds_next;
  logic [SUBSEC_BITS+9:0]   ms_prod_next;

  // Whole seconds modulo 2^32, and the ticks scaled to thousandths.
  always_comb begin
    seconds_next = SEC_W'(in_beat.days * SEC_W'(SEC_PER_DAY)) + SEC_W'(in_beat.hms);
    ms_prod_next = (SUBSEC_BITS + 10)'(in_ticks) * (SUBSEC_BITS + 10)'(MS_PER_SEC);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seconds <= seconds_next;
      ticks   <= in_ticks;
      ms_prod <= ms_prod_next;
    end
  end

endmodule

### src/calts_scale.sv
module calts_scale #(
  parameter int SUBSEC_BITS = calts_pkg::SUBSEC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [calts_pkg::SEC_W-1:0]   seconds,
  input  logic [SUBSEC_BITS-1:0]        ticks,
  input  logic [SUBSEC_BITS+9:0]        ms_prod,
  output logic                          out_valid,
  input  logic                          out_ready,
  output calts_pkg::scale_beat_t        out_beat
);
  import calts_pkg::*;

  localparam int CAT_W = SEC_W + SUBSEC_BITS;

  logic [CAT_W-1:0] cat;
  scale_beat_t      beat_next;

  // Tick timestamp is the seconds with the ticks below them; milliseconds
  // drop the sub-second fraction bits.
  always_comb begin
    cat                  = {seconds, ticks};
    beat_next.seconds    = seconds;
    beat_next.seconds_ms = SEC_W'(seconds * SEC_W'(MS_PER_SEC));
    beat_next.ms         = MS_W'(ms_prod >> SUBSEC_BITS);
    beat_next.ts         = TS_W'(cat);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

### src/calts_out.sv
module calts_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  calts_pkg::scale_beat_t        in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [calts_pkg::SEC_W-1:0]   elapsed_seconds,
  output logic [calts_pkg::TS_W-1:0]    tick_timestamp,
  output logic [calts_pkg::MS_W-1:0]    subsecond_ms,
  output logic [calts_pkg::SEC_W-1:0]   total_ms
);
  import calts_pkg::*;

  logic [SEC_W-1:0] total_next;

  // Total milliseconds, wrapping modulo 2^32.
  assign total_next = in_beat.seconds_ms + SEC_W'(in_beat.ms);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output register holds the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      elapsed_seconds <= in_beat.seconds;
      tick_timestamp  <= in_beat.ts;
      subsecond_ms    <= in_beat.ms;
      total_ms        <= total_next;
    end
  end

endmodule
